// ----- rtl/core/bshm_pkg.sv -----
`default_nettype none

package bshm_pkg;

   localparam int RefFracBits = 16;
   localparam int RefWidth    = 24 + RefFracBits;
   localparam int GainWidth   = 16;
   localparam int GainFrac    = 16;
   localparam int ProdWidth   = RefWidth + GainWidth;

   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 24;

   localparam logic [CsrIdxWidth-1:0] CSR_DEVICE_READY  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ERROR_LIMIT   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_STALE_TIME    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_TRACK_GAIN    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESS_MIN     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESS_MAX     = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_TEMP_MIN      = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CSR_TEMP_MAX      = 3'd7;

   localparam logic CMD_POLL  = 1'b0;
   localparam logic CMD_TRACK = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_READY = 2'd1;
   localparam logic [1:0] STATUS_NO_DATA   = 2'd2;
   localparam logic [1:0] STATUS_FAILED    = 2'd3;

   localparam logic [7:0]  FAIL_SAT          = 8'd255;
   localparam logic [23:0] GROUND_RESET_INT  = 24'd6484800;

   localparam logic [7:0]         ERROR_LIMIT_RST = 8'd8;
   localparam logic [15:0]        STALE_TIME_RST  = 16'd500;
   localparam logic [15:0]        TRACK_GAIN_RST  = 16'd64;
   localparam logic [23:0]        PRESS_MIN_RST   = 24'd768000;
   localparam logic [23:0]        PRESS_MAX_RST   = 24'd7040000;
   localparam logic signed [23:0] TEMP_MIN_RST    = -24'sd2621440;
   localparam logic signed [23:0] TEMP_MAX_RST    = 24'sd5570560;

   typedef struct packed {
      logic        command;
      logic [31:0] now_ms;
      logic        status_read_ok;
      logic [7:0]  irq_status;
      logic        burst_ok;
      logic [23:0] temp_word;
      logic [23:0] press_word;
   } req_type;

   typedef struct packed {
      logic [1:0]         read_status;
      logic [23:0]        pressure_out;
      logic signed [23:0] temperature_out;
      logic               healthy;
      logic [23:0]        reference_pressure;
      logic [7:0]         failure_count;
   } rsp_type;

   typedef struct packed {
      logic               device_ready;
      logic [7:0]         error_limit;
      logic [15:0]        stale_time_ms;
      logic [15:0]        track_gain;
      logic [23:0]        pressure_min_raw;
      logic [23:0]        pressure_max_raw;
      logic signed [23:0] temp_min_raw;
      logic signed [23:0] temp_max_raw;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/bshm_req_if.sv -----
`default_nettype none

interface bshm_req_if;
   import bshm_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bshm_rsp_if.sv -----
`default_nettype none

interface bshm_rsp_if;
   import bshm_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bshm_csr_if.sv -----
`default_nettype none

interface bshm_csr_if;
   import bshm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CsrIdxWidth-1:0]  index;
   logic [CsrDataWidth-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bshm_cfg_regs.sv -----
`default_nettype none

module bshm_cfg_regs (
   input  wire logic              clock,
   input  wire logic              reset,
   bshm_csr_if.sink               csr_chan,
   output bshm_pkg::cfg_type      cfg
);
   import bshm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_DEVICE_READY: cfg_in.device_ready     = csr_chan.data[0];
            CSR_ERROR_LIMIT:  cfg_in.error_limit      = csr_chan.data[7:0];
            CSR_STALE_TIME:   cfg_in.stale_time_ms    = csr_chan.data[15:0];
            CSR_TRACK_GAIN:   cfg_in.track_gain       = csr_chan.data[15:0];
            CSR_PRESS_MIN:    cfg_in.pressure_min_raw = csr_chan.data;
            CSR_PRESS_MAX:    cfg_in.pressure_max_raw = csr_chan.data;
            CSR_TEMP_MIN:     cfg_in.temp_min_raw     = $signed(csr_chan.data);
            CSR_TEMP_MAX:     cfg_in.temp_max_raw     = $signed(csr_chan.data);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_ready     <= 1'b0;
         cfg_ff.error_limit      <= ERROR_LIMIT_RST;
         cfg_ff.stale_time_ms    <= STALE_TIME_RST;
         cfg_ff.track_gain       <= TRACK_GAIN_RST;
         cfg_ff.pressure_min_raw <= PRESS_MIN_RST;
         cfg_ff.pressure_max_raw <= PRESS_MAX_RST;
         cfg_ff.temp_min_raw     <= TEMP_MIN_RST;
         cfg_ff.temp_max_raw     <= TEMP_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bshm_core.sv -----
`default_nettype none

module bshm_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire bshm_pkg::req_type item,
   input  wire bshm_pkg::cfg_type cfg,
   output bshm_pkg::rsp_type      result
);
   import bshm_pkg::*;

   logic [7:0]          fail_count_ff, fail_count_in;
   logic                have_sample_ff, have_sample_in;
   logic [31:0]         fresh_time_ff, fresh_time_in;
   logic [23:0]         cached_press_ff, cached_press_in;
   logic [23:0]         cached_temp_ff, cached_temp_in;
   logic [RefWidth-1:0] ground_ref_ff, ground_ref_in;

   logic                sample_good;
   logic [RefWidth-1:0] target;
   logic                track_up;
   logic [RefWidth-1:0] track_mag;
   logic [ProdWidth-1:0] track_prod;
   logic [ProdWidth-1:0] track_round;
   logic [RefWidth-1:0] track_delta;
   logic [31:0]         age;
   logic                stale;
   logic                err_limited;

   assign sample_good = item.burst_ok && (item.press_word != 24'd0)
                        && (item.press_word >= cfg.pressure_min_raw)
                        && (item.press_word <= cfg.pressure_max_raw)
                        && ($signed(item.temp_word) >= cfg.temp_min_raw)
                        && ($signed(item.temp_word) <= cfg.temp_max_raw);

   // ground tracking: rounded Q0.16 step of the distance to the cached pressure
   assign target      = {cached_press_ff, {RefFracBits{1'b0}}};
   assign track_up    = target >= ground_ref_ff;
   assign track_mag   = track_up ? (target - ground_ref_ff) : (ground_ref_ff - target);
   assign track_prod  = ProdWidth'(track_mag) * ProdWidth'(cfg.track_gain);
   assign track_round = track_prod + (ProdWidth'(1) << (GainFrac - 1));
   assign track_delta = track_round[GainFrac +: RefWidth];

   always_comb begin
      fail_count_in   = fail_count_ff;
      have_sample_in  = have_sample_ff;
      fresh_time_in   = fresh_time_ff;
      cached_press_in = cached_press_ff;
      cached_temp_in  = cached_temp_ff;
      ground_ref_in   = ground_ref_ff;
      if (cfg.device_ready) begin
         if (item.command == CMD_POLL) begin
            if (!item.status_read_ok) begin
               if (fail_count_ff != FAIL_SAT) fail_count_in = fail_count_ff + 8'd1;
            end else if (item.irq_status[0]) begin
               if (sample_good) begin
                  cached_press_in = item.press_word;
                  cached_temp_in  = item.temp_word;
                  have_sample_in  = 1'b1;
                  fresh_time_in   = item.now_ms;
                  fail_count_in   = 8'd0;
               end else if (fail_count_ff != FAIL_SAT) begin
                  fail_count_in = fail_count_ff + 8'd1;
               end
            end
         end else if (have_sample_ff && (ground_ref_ff != '0)) begin
            ground_ref_in = track_up ? (ground_ref_ff + track_delta)
                                     : (ground_ref_ff - track_delta);
         end
      end
   end

   // status looks at the state after this step's update
   assign age         = item.now_ms - fresh_time_in;
   assign stale       = age > {16'd0, cfg.stale_time_ms};
   assign err_limited = fail_count_in >= cfg.error_limit;

   always_comb begin
      if (!cfg.device_ready)          result.read_status = STATUS_NOT_READY;
      else if (!have_sample_in)       result.read_status = STATUS_NO_DATA;
      else if (err_limited || stale)  result.read_status = STATUS_FAILED;
      else                            result.read_status = STATUS_OK;
      result.pressure_out       = cached_press_in;
      result.temperature_out    = $signed(cached_temp_in);
      result.healthy            = cfg.device_ready && !err_limited
                                  && !(have_sample_in && stale);
      result.reference_pressure = ground_ref_in[RefFracBits +: 24];
      result.failure_count      = fail_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_count_ff   <= 8'd0;
         have_sample_ff  <= 1'b0;
         fresh_time_ff   <= 32'd0;
         cached_press_ff <= 24'd0;
         cached_temp_ff  <= 24'd0;
         ground_ref_ff   <= {GROUND_RESET_INT, {RefFracBits{1'b0}}};
      end else if (advance) begin
         fail_count_ff   <= fail_count_in;
         have_sample_ff  <= have_sample_in;
         fresh_time_ff   <= fresh_time_in;
         cached_press_ff <= cached_press_in;
         cached_temp_ff  <= cached_temp_in;
         ground_ref_ff   <= ground_ref_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/barometer_sample_health_monitor.sv -----
// Barometer sample health monitor.
//
// req_chan carries one request per poll or ground tracking step; rsp_chan
// returns exactly one result per request, in order. csr_chan writes the
// eight configuration registers by index and is always ready; write it
// only while no request is in flight.
//
// A request lands in an input register; from there the state update and
// result are computed in one pass (one 40x16 multiply on the tracking
// path) and captured in the result register once it is free or being
// read. rsp_chan.valid is driven by the result register, and one request
// per cycle is sustained while rsp_chan is ready.
//
// When rsp_chan stalls, the result register holds and the input register
// still takes one more request; req_chan.ready drops only when both are
// full. Reset empties both stages, loads the register defaults (device not
// ready) and clears the cached sample, failure count and timestamp; the
// ground reference returns to its default. No clearing pass is needed.
`default_nettype none

module barometer_sample_health_monitor (
   input  wire logic  clock,
   input  wire logic  reset,
   bshm_req_if.sink   req_chan,
   bshm_rsp_if.source rsp_chan,
   bshm_csr_if.sink   csr_chan
);
   import bshm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type result;
   cfg_type cfg;
   logic    advance;
   logic    accept;

   bshm_cfg_regs u_cfg_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   bshm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_data_ff <= req_chan.data;
      if (advance) out_data_ff <= result;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

`default_nettype wire
